>>> hw/rtl/lpd_pkg.sv
// shared types and constants for the launch phase detector
package lpd_pkg;

   typedef enum logic [1:0] {
      FLIGHT_ARMED = 2'd0,
      FLIGHT_BOOST = 2'd1,
      FLIGHT_COAST = 2'd2,
      FLIGHT_HELD  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START  = 1'b1;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_TRIP_LEVEL    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BURNOUT_LEVEL = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_BOOST     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOOT_MODE     = 2'd3;

   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 48;
   localparam int MIN_BOOST_W = 32;

   localparam logic [SAMPLE_W-1:0]    TRIP_RESET    = 16'd3000;
   localparam logic [SAMPLE_W-1:0]    BURNOUT_RESET = 16'd1500;
   localparam logic [MIN_BOOST_W-1:0] MIN_BOOST_RESET = 32'd1000000;

endpackage

>>> hw/rtl/lpd_ram.sv
// generic single write port ram with registered read
module lpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lpd_div.sv
// serial restoring divider, one quotient bit per cycle
module lpd_div #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff      = rem_shift - {1'b0, divisor};
      fits      = rem_shift >= {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // dividend shifts out the top while quotient bits fill the bottom
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> hw/rtl/launch_phase_detector_core.sv
// launch phase detector top level: sequencer, window bookkeeping and mode logic
//
// req channel: one beat per item. req_tuser is the command (0 sample, 1 start),
// req_tdata carries the acceleration sample and the microsecond timestamp.
// rsp channel: one beat per item with mode, mode change flag and window average.
// csr port: csr_we writes csr_wdata into register csr_addr (0 trip level,
// 1 burnout level, 2 minimum boost time, 3 boot mode); write only while idle.
// Sequence: a sample item passes the read, update, divider start, divider wait
// and output steps before rsp_tvalid; the serial divider produces one quotient
// bit per cycle in the wait step. A start item skips the read and update steps,
// or goes straight to the output step when no sample has been taken. req_tready
// is high only when the sequencer is idle, so one item is in work at a time and
// the next beat is taken only once the sequencer is back in the idle step.
// A finished result waits in the rsp register; while an earlier result still
// waits with rsp_tready low the sequencer holds in its last step, taking no item.
// Reset (synchronous) empties the window, clears the sum and returns the mode
// to armed; the window ram contents are not cleared and need no sweep.
module launch_phase_detector_core #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [15:0] accel_mg, [63:16] now_us
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] mode, [2] mode_changed, [18:3] average_mg
   input  logic        csr_we,
   input  logic [lpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lpd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW    = lpd_pkg::SAMPLE_W;
   localparam int TW    = lpd_pkg::TIME_W;
   localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = SW + $clog2(WINDOW_DEPTH);

   // configuration
   logic [SW-1:0]                   trip_ff;
   logic [SW-1:0]                   burnout_ff;
   logic [lpd_pkg::MIN_BOOST_W-1:0] min_boost_ff;
   lpd_pkg::mode_type               boot_mode_ff;

   // sequencer and item state
   lpd_pkg::state_type state_ff, state_in;
   logic               cmd_ff;
   logic [SW-1:0]      accel_ff;
   logic [TW-1:0]      now_ff;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   lpd_pkg::mode_type  mode_ff, mode_in;
   logic [TW-1:0]      boost_start_ff, boost_start_in;

   logic               rsp_valid_ff, rsp_valid_in;
   lpd_pkg::mode_type  rsp_mode_ff;
   logic               rsp_changed_ff;
   logic [SW-1:0]      rsp_avg_ff;

   // control from the output decode
   logic accept, ram_rd, ram_wr, div_start, out_fire;

   logic [SW-1:0]    ram_rd_data;
   logic             div_done;
   logic [SUM_W-1:0] quotient;
   logic [SW-1:0]    avg;
   logic             full;
   logic [TW-1:0]    elapsed;

   lpd_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (pos_ff),
      .wr_data (accel_ff),
      .rd_en   (ram_rd),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   lpd_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trip_ff      <= lpd_pkg::TRIP_RESET;
         burnout_ff   <= lpd_pkg::BURNOUT_RESET;
         min_boost_ff <= lpd_pkg::MIN_BOOST_RESET;
         boot_mode_ff <= lpd_pkg::FLIGHT_ARMED;
      end else if (csr_we) begin
         unique case (csr_addr)
            lpd_pkg::CSR_TRIP_LEVEL:    trip_ff      <= csr_wdata[SW-1:0];
            lpd_pkg::CSR_BURNOUT_LEVEL: burnout_ff   <= csr_wdata[SW-1:0];
            lpd_pkg::CSR_MIN_BOOST:     min_boost_ff <= csr_wdata[lpd_pkg::MIN_BOOST_W-1:0];
            lpd_pkg::CSR_BOOT_MODE:     boot_mode_ff <= lpd_pkg::mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == lpd_pkg::CMD_SAMPLE) begin
                  state_in = lpd_pkg::ST_READ;
               end else if (fill_ff == '0) begin
                  state_in = lpd_pkg::ST_OUT;
               end else begin
                  state_in = lpd_pkg::ST_DIV_START;
               end
            end
         end
         lpd_pkg::ST_READ:      state_in = lpd_pkg::ST_UPDATE;
         lpd_pkg::ST_UPDATE:    state_in = lpd_pkg::ST_DIV_START;
         lpd_pkg::ST_DIV_START: state_in = lpd_pkg::ST_DIV_WAIT;
         lpd_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = lpd_pkg::ST_OUT;
            end
         end
         lpd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = lpd_pkg::ST_IDLE;
            end
         end
         default: state_in = lpd_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      ram_rd     = 1'b0;
      ram_wr     = 1'b0;
      div_start  = 1'b0;
      out_fire   = 1'b0;
      unique case (state_ff)
         lpd_pkg::ST_IDLE:      req_tready = 1'b1;
         lpd_pkg::ST_READ:      ram_rd     = 1'b1;
         lpd_pkg::ST_UPDATE:    ram_wr     = 1'b1;
         lpd_pkg::ST_DIV_START: div_start  = 1'b1;
         lpd_pkg::ST_DIV_WAIT:  ;
         lpd_pkg::ST_OUT:       out_fire   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // datapath next values
   always_comb begin
      full    = fill_ff == CNT_W'(WINDOW_DEPTH);
      avg     = (fill_ff == '0) ? '0 : quotient[SW-1:0];
      elapsed = now_ff - boost_start_ff;

      pos_in         = pos_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      mode_in        = mode_ff;
      boost_start_in = boost_start_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (ram_wr) begin
         // oldest entry leaves the sum once the window is full
         sum_in = sum_ff - (full ? SUM_W'(ram_rd_data) : '0) + SUM_W'(accel_ff);
         if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         pos_in = (pos_ff == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + POS_W'(1);
      end

      if (out_fire) begin
         rsp_valid_in = 1'b1;
         if (cmd_ff == lpd_pkg::CMD_START) begin
            mode_in = boot_mode_ff;
            if (boot_mode_ff == lpd_pkg::FLIGHT_BOOST) begin
               boost_start_in = now_ff;
            end
         end else if (mode_ff == lpd_pkg::FLIGHT_ARMED) begin
            if (avg >= trip_ff) begin
               mode_in        = lpd_pkg::FLIGHT_BOOST;
               boost_start_in = now_ff;
            end
         end else if (mode_ff == lpd_pkg::FLIGHT_BOOST) begin
            if (avg < burnout_ff && elapsed >= TW'(min_boost_ff)) begin
               mode_in = lpd_pkg::FLIGHT_COAST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lpd_pkg::ST_IDLE;
         pos_ff         <= '0;
         fill_ff        <= '0;
         sum_ff         <= '0;
         mode_ff        <= lpd_pkg::FLIGHT_ARMED;
         boost_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         fill_ff        <= fill_in;
         sum_ff         <= sum_in;
         mode_ff        <= mode_in;
         boost_start_ff <= boost_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff   <= req_tuser;
         accel_ff <= req_tdata[SW-1:0];
         now_ff   <= req_tdata[SW+TW-1:SW];
      end
      if (out_fire) begin
         rsp_mode_ff    <= mode_in;
         rsp_changed_ff <= mode_in != mode_ff;
         rsp_avg_ff     <= avg;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_avg_ff, rsp_changed_ff, rsp_mode_ff};

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("item accepted while another is in work");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("fill count beyond window depth");

   a_terminal: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == lpd_pkg::FLIGHT_COAST || mode_ff == lpd_pkg::FLIGHT_HELD) &&
      !(out_fire && cmd_ff == lpd_pkg::CMD_START) |=> mode_ff == $past(mode_ff))
      else $error("terminal mode left without start");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == lpd_pkg::ST_DIV_WAIT)
      else $error("divider finished outside wait step");
`endif

endmodule

>>> tb/lpd_checker.sv
// checker for the launch phase detector: watches the channels, predicts results and compares
module lpd_checker #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [63:0]                    req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [23:0]                    rsp_tdata,
   input  logic                           csr_we,
   input  logic [lpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             errors,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      lpd_pkg::mode_type            mode;
      logic                         changed;
      logic [lpd_pkg::SAMPLE_W-1:0] avg;
   } status_type;

   // register copies
   logic [lpd_pkg::SAMPLE_W-1:0]    trip_level;
   logic [lpd_pkg::SAMPLE_W-1:0]    burnout_level;
   logic [lpd_pkg::MIN_BOOST_W-1:0] min_boost;
   lpd_pkg::mode_type               boot_mode;

   // flight state
   logic [lpd_pkg::SAMPLE_W-1:0] samples [DEPTH];
   int unsigned                  next_slot;
   int unsigned                  filled;
   logic [19:0]                  sample_sum;
   lpd_pkg::mode_type            mode_now;
   logic [lpd_pkg::TIME_W-1:0]   boost_t0;

   status_type expected_status[$];
   int         fault_count;
   int         rsp_index;

   function automatic logic [lpd_pkg::SAMPLE_W-1:0] window_mean();
      if (filled == 0)
         return '0;
      return lpd_pkg::SAMPLE_W'(sample_sum / filled);
   endfunction

   function automatic status_type advance_flight(logic cmd,
                                                 logic [lpd_pkg::SAMPLE_W-1:0] accel,
                                                 logic [lpd_pkg::TIME_W-1:0] now_us);
      status_type                   r;
      lpd_pkg::mode_type            prior;
      logic [lpd_pkg::SAMPLE_W-1:0] avg;
      prior = mode_now;
      if (cmd == lpd_pkg::CMD_START) begin
         mode_now = boot_mode;
         if (mode_now == lpd_pkg::FLIGHT_BOOST)
            boost_t0 = now_us;
         avg = window_mean();
      end else begin
         // full window: oldest entry leaves the sum
         if (filled < DEPTH)
            filled++;
         else
            sample_sum -= samples[next_slot];
         samples[next_slot] = accel;
         sample_sum += accel;
         next_slot = (next_slot + 1) % DEPTH;
         avg = window_mean();
         case (mode_now)
            lpd_pkg::FLIGHT_ARMED: begin
               if (avg >= trip_level) begin
                  mode_now = lpd_pkg::FLIGHT_BOOST;
                  boost_t0 = now_us;
               end
            end
            lpd_pkg::FLIGHT_BOOST: begin
               // elapsed time wraps at 48 bits
               if (avg < burnout_level && lpd_pkg::TIME_W'(now_us - boost_t0) >=
                   lpd_pkg::TIME_W'(min_boost))
                  mode_now = lpd_pkg::FLIGHT_COAST;
            end
            default: ;
         endcase
      end
      r.mode    = mode_now;
      r.changed = (mode_now != prior);
      r.avg     = avg;
      return r;
   endfunction

   always @(posedge clock) begin
      status_type want;
      status_type got;
      if (reset) begin
         trip_level    = lpd_pkg::TRIP_RESET;
         burnout_level = lpd_pkg::BURNOUT_RESET;
         min_boost     = lpd_pkg::MIN_BOOST_RESET;
         boot_mode     = lpd_pkg::FLIGHT_ARMED;
         next_slot     = 0;
         filled        = 0;
         sample_sum    = '0;
         mode_now      = lpd_pkg::FLIGHT_ARMED;
         boost_t0      = '0;
         fault_count   = 0;
         rsp_index     = 0;
         expected_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               lpd_pkg::CSR_TRIP_LEVEL:
                  trip_level    = csr_wdata[lpd_pkg::SAMPLE_W-1:0];
               lpd_pkg::CSR_BURNOUT_LEVEL:
                  burnout_level = csr_wdata[lpd_pkg::SAMPLE_W-1:0];
               lpd_pkg::CSR_MIN_BOOST:
                  min_boost     = csr_wdata[lpd_pkg::MIN_BOOST_W-1:0];
               lpd_pkg::CSR_BOOT_MODE:
                  boot_mode     = lpd_pkg::mode_type'(csr_wdata[1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.mode    = lpd_pkg::mode_type'(rsp_tdata[1:0]);
            got.changed = rsp_tdata[2];
            got.avg     = rsp_tdata[18:3];
            if (expected_status.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: result beat %0d arrived with nothing expected", $realtime,
                           rsp_index);
            end else begin
               want = expected_status.pop_front();
               if (got.mode !== want.mode || got.changed !== want.changed ||
                   got.avg !== want.avg) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%0t: beat %0d mode %0d/%0d changed %0b/%0b average %0d/%0d %s",
                              $realtime, rsp_index, want.mode, got.mode, want.changed,
                              got.changed, want.avg, got.avg, "(expected/actual)");
               end
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready)
            expected_status.push_back(advance_flight(req_tuser, req_tdata[15:0],
                                                     req_tdata[63:16]));
      end
      errors  <= fault_count;
      pending <= expected_status.size();
   end

endmodule

>>> tb/tb.sv
// top of the launch phase detector testbench: clock, reset, stimulus and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lpd_pkg::TIME_W-1:0] TIME_MAX = '1;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [63:0]                    req_tdata  = '0;
   logic                           req_tuser  = lpd_pkg::CMD_SAMPLE;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [23:0]                    rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [lpd_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [lpd_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   logic                       calm = 1'b0;
   int                         mismatches;
   int                         outstanding;
   int                         sent = 0;
   logic [lpd_pkg::TIME_W-1:0] stamp_us;

   launch_phase_detector_core #(.WINDOW_DEPTH(16)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   lpd_checker #(.DEPTH(16)) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .errors     (mismatches),
      .pending    (outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 23);
   end

   task automatic send_item(input logic cmd, input logic [lpd_pkg::SAMPLE_W-1:0] accel,
                            input logic [lpd_pkg::TIME_W-1:0] now_us);
      while (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {now_us, accel};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sent++;
   endtask

   // hold the sender until every result beat is back and the block is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || !req_tready)
         @(posedge clock);
   endtask

   task automatic configure(input logic [lpd_pkg::SAMPLE_W-1:0] trip,
                            input logic [lpd_pkg::SAMPLE_W-1:0] burnout,
                            input logic [lpd_pkg::MIN_BOOST_W-1:0] min_boost,
                            input lpd_pkg::mode_type boot);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= lpd_pkg::CSR_TRIP_LEVEL;
      csr_wdata <= {16'($urandom), trip};
      @(posedge clock);
      csr_addr  <= lpd_pkg::CSR_BURNOUT_LEVEL;
      csr_wdata <= {16'($urandom), burnout};
      @(posedge clock);
      csr_addr  <= lpd_pkg::CSR_MIN_BOOST;
      csr_wdata <= min_boost;
      @(posedge clock);
      csr_addr  <= lpd_pkg::CSR_BOOT_MODE;
      csr_wdata <= {30'($urandom), boot};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [lpd_pkg::SAMPLE_W-1:0]    trip;
      logic [lpd_pkg::SAMPLE_W-1:0]    burnout;
      logic [lpd_pkg::SAMPLE_W-1:0]    level;
      logic [lpd_pkg::MIN_BOOST_W-1:0] min_boost;
      lpd_pkg::mode_type               boot;
      int                              n_pre;
      int                              n_hi;
      int                              n_total;
      int                              phase;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // start before any sample reads a zero average
      send_item(lpd_pkg::CMD_START, 16'hFFFF, 48'd0);
      send_item(lpd_pkg::CMD_SAMPLE, 16'h0000, 48'd100);
      send_item(lpd_pkg::CMD_SAMPLE, 16'hFFFF, 48'd200);
      send_item(lpd_pkg::CMD_SAMPLE, 16'h0000, 48'd300);
      send_item(lpd_pkg::CMD_SAMPLE, 16'h0000, 48'd1000400);

      // boot into boost near the time wrap, then overfill the window
      configure(16'hFFFF, 16'h0000, 32'd0, lpd_pkg::FLIGHT_BOOST);
      send_item(lpd_pkg::CMD_START, 16'h0000, TIME_MAX - 48'd20);
      for (int k = 0; k < 14; k++)
         send_item(lpd_pkg::CMD_SAMPLE, 16'hFFFF,
                   TIME_MAX - 48'd20 + lpd_pkg::TIME_W'(k * 3));

      configure(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, lpd_pkg::FLIGHT_HELD);
      send_item(lpd_pkg::CMD_START, 16'h0000, 48'd5000);
      send_item(lpd_pkg::CMD_SAMPLE, 16'h0000, 48'd5100);

      configure(16'h0000, 16'hFFFF, 32'd120, lpd_pkg::FLIGHT_COAST);
      send_item(lpd_pkg::CMD_START, 16'hFFFF, 48'd6000);

      // boost entered just before the wrap, coast only once the wrapped elapsed time is enough
      configure(16'h0000, 16'hFFFF, 32'd120, lpd_pkg::FLIGHT_ARMED);
      send_item(lpd_pkg::CMD_START, 16'h0000, TIME_MAX - 48'd50);
      send_item(lpd_pkg::CMD_SAMPLE, 16'h1234, TIME_MAX - 48'd50);
      send_item(lpd_pkg::CMD_SAMPLE, 16'h0000, 48'd60);
      send_item(lpd_pkg::CMD_SAMPLE, 16'h0000, 48'd100);

      for (phase = 0; sent < 830; phase++) begin
         case ($urandom_range(9))
            0:       trip = 16'h0000;
            1:       trip = 16'hFFFF;
            default: trip = 16'($urandom_range(1000, 60000));
         endcase
         case ($urandom_range(9))
            0:       burnout = 16'h0000;
            1:       burnout = 16'hFFFF;
            default: burnout = 16'($urandom_range(0, trip));
         endcase
         case ($urandom_range(9))
            0:       min_boost = 32'd0;
            1:       min_boost = 32'hFFFF_FFFF;
            default: min_boost = $urandom_range(0, 3000);
         endcase
         boot = ($urandom_range(3) < 2) ? lpd_pkg::FLIGHT_ARMED :
                                          lpd_pkg::mode_type'($urandom_range(3));
         configure(trip, burnout, min_boost, boot);
         calm = (phase == 4);

         if ($urandom_range(4) == 0)
            stamp_us = TIME_MAX - lpd_pkg::TIME_W'($urandom_range(0, 3000));
         else
            stamp_us = {16'($urandom), 32'($urandom)};
         send_item(lpd_pkg::CMD_START, 16'($urandom), stamp_us);

         // quiet pad, burn above trip, then tail-off below burnout
         n_pre   = $urandom_range(0, 10);
         n_hi    = $urandom_range(5, 30);
         n_total = n_pre + n_hi + $urandom_range(5, 25);
         for (int i = 0; i < n_total; i++) begin
            stamp_us += lpd_pkg::TIME_W'($urandom_range(0, 200));
            if ($urandom_range(99) < 8) begin
               case ($urandom_range(2))
                  0: send_item(lpd_pkg::CMD_START, 16'($urandom), stamp_us);
                  1: send_item(lpd_pkg::CMD_SAMPLE, 16'($urandom), stamp_us);
                  default: begin
                     stamp_us = {16'($urandom), 32'($urandom)};
                     send_item(lpd_pkg::CMD_SAMPLE, 16'($urandom), stamp_us);
                  end
               endcase
            end else begin
               if (i < n_pre)
                  level = 16'($urandom_range(0, (trip > 0) ? trip - 1 : 0));
               else if (i < n_pre + n_hi)
                  level = 16'($urandom_range(trip, 16'hFFFF));
               else
                  level = 16'($urandom_range(0, (burnout > 0) ? burnout - 1 : 0));
               send_item(lpd_pkg::CMD_SAMPLE, level, stamp_us);
            end
         end
         calm = 1'b0;
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
